[rtl/core/stex_pkg.sv]
// Shared types, constants and helpers for the simple-TLV serial extractor.
// No dependencies.
package stex_pkg;

	// Parser phase of the front end
	typedef enum logic [2:0] {
		PH_TAG,
		PH_LEN,
		PH_LENHI,
		PH_LENLO,
		PH_SKIP,
		PH_VALUE,
		PH_DONE
	} phase_t;

	// Final status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_OVERRUN  = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	localparam logic [7:0] TAG_RESET = 8'h5A;
	localparam logic [7:0] LEN_EXT   = 8'hFF;
	localparam logic [15:0] LEN_THIRTEEN = 16'd13;

	// Queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Emission steps of one command: six prefix chars, two hex chars, status
	typedef logic [3:0] step_t;
	localparam step_t STEP_PFX0 = 4'd0;
	localparam step_t STEP_PFX1 = 4'd1;
	localparam step_t STEP_PFX5 = 4'd5;
	localparam step_t STEP_HI   = 4'd6;
	localparam step_t STEP_LO   = 4'd7;
	localparam step_t STEP_ST   = 4'd8;

	localparam logic [7:0] CHAR_F = 8'h46;
	localparam logic [7:0] CHAR_0 = 8'h30;

	// Work for the back end produced by one input byte
	typedef struct packed {
		logic       pfx;     // emit FF0000 first
		logic       hex;     // emit two hex chars of data
		logic       has_st;  // close with a status result
		logic [1:0] st;
		logic [7:0] data;
	} cmd_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) r = 8'h30 + {4'h0, nib};
		else r = 8'h37 + {4'h0, nib};
		return r;
	endfunction

endpackage

[rtl/core/simple_tlv_serial_extractor_top.sv]
// Simple-TLV serial extractor: accepts one file byte per beat, emits hex chars of
// the matching record's value and one closing status beat per run.
// A taken byte is stored in the queue, then in the back end's command and output registers.
// Throughput is set by the back end: one result beat per cycle unless out_ready stalls.
// The front end takes a byte every cycle while the 4-entry queue has room.
// Reset: arst_n clears all control state, target_tag returns to 0x5A.
module simple_tlv_serial_extractor_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_status,
	output logic [7:0] out_char,
	output logic [1:0] status,
	output logic       last_result
);

	logic push_valid, push_ready, pop_valid, pop_ready;
	stex_pkg::cmd_t push_data, pop_data;

	stex_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.last_byte  (last_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	stex_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	stex_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_data    (pop_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.is_status   (is_status),
		.out_char    (out_char),
		.status      (status),
		.last_result (last_result)
	);

endmodule

[rtl/core/stex_front.sv]
// Front end: TLV header walker and classifier, one byte per beat.
// Depends on stex_pkg.
module stex_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               last_byte,
	output logic               push_valid,
	input  logic               push_ready,
	output stex_pkg::cmd_t     push_data
);

	stex_pkg::phase_t phase_q, phase_d;
	logic [15:0] rem_q, rem_d, rem_v;
	logic        matched_q, matched_d;
	logic [7:0]  lenhi_q, lenhi_d;
	logic        thirteen_q, thirteen_d;
	logic        first_q, first_d;
	logic [7:0]  target_tag_q;
	logic        hdr_go, push, accept;
	stex_pkg::cmd_t cmd;

	assign in_ready = push_ready;
	assign accept = in_valid && in_ready;
	assign push_valid = accept && push;
	assign push_data = cmd;

	always_comb begin
		phase_d = phase_q;
		rem_d = rem_q;
		rem_v = rem_q;
		matched_d = matched_q;
		lenhi_d = lenhi_q;
		thirteen_d = thirteen_q;
		first_d = first_q;
		hdr_go = 1'b0;
		push = 1'b0;
		cmd = '0;
		cmd.data = in_byte;
		case (phase_q)
			stex_pkg::PH_TAG: begin
				matched_d = (in_byte == target_tag_q);
				if (last_byte) begin
					push = 1'b1; cmd.has_st = 1'b1; cmd.st = stex_pkg::ST_NOTFOUND;
				end else phase_d = stex_pkg::PH_LEN;
			end
			stex_pkg::PH_LEN: begin
				if (in_byte == stex_pkg::LEN_EXT) begin
					if (last_byte) begin
						push = 1'b1; cmd.has_st = 1'b1; cmd.st = stex_pkg::ST_NOTFOUND;
					end else phase_d = stex_pkg::PH_LENHI;
				end else begin
					rem_v = {8'h00, in_byte};
					rem_d = rem_v;
					hdr_go = 1'b1;
				end
			end
			stex_pkg::PH_LENHI: begin
				lenhi_d = in_byte;
				if (last_byte) begin
					push = 1'b1; cmd.has_st = 1'b1; cmd.st = stex_pkg::ST_NOTFOUND;
				end else phase_d = stex_pkg::PH_LENLO;
			end
			stex_pkg::PH_LENLO: begin
				rem_v = {lenhi_q, in_byte};
				rem_d = rem_v;
				hdr_go = 1'b1;
			end
			stex_pkg::PH_SKIP: begin
				rem_v = rem_q - 16'd1;
				rem_d = rem_v;
				if (last_byte) begin
					push = 1'b1; cmd.has_st = 1'b1; cmd.st = stex_pkg::ST_NOTFOUND;
				end else if (rem_v == 16'd0) phase_d = stex_pkg::PH_TAG;
			end
			stex_pkg::PH_VALUE: begin
				push = 1'b1;
				cmd.hex = 1'b1;
				cmd.pfx = first_q && (in_byte == 8'hFF);
				first_d = 1'b0;
				rem_v = rem_q - 16'd1;
				rem_d = rem_v;
				if (rem_v == 16'd0) begin
					cmd.has_st = 1'b1; cmd.st = stex_pkg::ST_OK;
				end else if (last_byte) begin
					cmd.has_st = 1'b1;
					// declared 13 with one byte missing still counts as ok
					cmd.st = (thirteen_q && rem_v == 16'd1) ? stex_pkg::ST_OK
						: stex_pkg::ST_OVERRUN;
				end
			end
			stex_pkg::PH_DONE: begin
				if (last_byte) phase_d = stex_pkg::PH_TAG;
			end
			default: phase_d = stex_pkg::PH_TAG;
		endcase

		// header complete: decide between value, skip and early status
		if (hdr_go) begin
			if (matched_q) begin
				if (rem_v == 16'd0) begin
					push = 1'b1; cmd.has_st = 1'b1; cmd.st = stex_pkg::ST_EMPTY;
				end else if (last_byte) begin
					push = 1'b1; cmd.has_st = 1'b1; cmd.st = stex_pkg::ST_OVERRUN;
				end else begin
					thirteen_d = (rem_v == stex_pkg::LEN_THIRTEEN);
					first_d = 1'b1;
					phase_d = stex_pkg::PH_VALUE;
				end
			end else if (last_byte) begin
				push = 1'b1; cmd.has_st = 1'b1; cmd.st = stex_pkg::ST_NOTFOUND;
			end else begin
				phase_d = (rem_v == 16'd0) ? stex_pkg::PH_TAG : stex_pkg::PH_SKIP;
			end
		end

		// any status ends the run
		if (cmd.has_st) phase_d = last_byte ? stex_pkg::PH_TAG : stex_pkg::PH_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= stex_pkg::PH_TAG;
			rem_q <= '0;
			matched_q <= 1'b0;
			lenhi_q <= '0;
			thirteen_q <= 1'b0;
			first_q <= 1'b1;
			target_tag_q <= stex_pkg::TAG_RESET;
		end else begin
			if (cfg_we) target_tag_q <= cfg_wdata;
			if (accept) begin
				phase_q <= phase_d;
				rem_q <= rem_d;
				matched_q <= matched_d;
				lenhi_q <= lenhi_d;
				thirteen_q <= thirteen_d;
				first_q <= first_d;
			end
		end
	end

endmodule

[rtl/core/stex_queue.sv]
// Short command queue between front and back end.
// Depends on stex_pkg.
module stex_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  stex_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output stex_pkg::cmd_t pop_data
);

	stex_pkg::cmd_t mem_q [stex_pkg::QDEPTH];
	logic [stex_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [stex_pkg::QCNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign push_ready = (cnt_q != stex_pkg::QCNT_W'(stex_pkg::QDEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[rtl/core/stex_back.sv]
// Back end: expands queued commands into result beats, one per cycle while out_ready
// allows, into a registered output stage. Depends on stex_pkg.
module stex_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  stex_pkg::cmd_t pop_data,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           is_status,
	output logic [7:0]     out_char,
	output logic [1:0]     status,
	output logic           last_result
);

	stex_pkg::cmd_t cmd_q;
	stex_pkg::step_t step_q, step_next, step_start;
	logic busy_q, out_valid_q, advance, last_step;
	logic is_status_q, last_result_q;
	logic [7:0] char_q, char_d;
	logic [1:0] status_q;

	assign advance = busy_q && (!out_valid_q || out_ready);
	assign last_step = (step_q == stex_pkg::STEP_ST) ||
		(step_q == stex_pkg::STEP_LO && !cmd_q.has_st);
	// next command is loaded on the same edge the current one finishes
	assign pop_ready = !busy_q || (advance && last_step);

	always_comb begin
		if (pop_data.pfx) step_start = stex_pkg::STEP_PFX0;
		else if (pop_data.hex) step_start = stex_pkg::STEP_HI;
		else step_start = stex_pkg::STEP_ST;

		step_next = step_q + 4'd1;

		case (step_q)
			stex_pkg::STEP_PFX0, stex_pkg::STEP_PFX1: char_d = stex_pkg::CHAR_F;
			stex_pkg::STEP_HI: char_d = stex_pkg::hex_char(cmd_q.data[7:4]);
			stex_pkg::STEP_LO: char_d = stex_pkg::hex_char(cmd_q.data[3:0]);
			stex_pkg::STEP_ST: char_d = 8'h00;
			default: char_d = stex_pkg::CHAR_0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) cmd_q <= pop_data;
		if (advance) begin
			char_q <= char_d;
			is_status_q <= (step_q == stex_pkg::STEP_ST);
			last_result_q <= (step_q == stex_pkg::STEP_ST);
			status_q <= (step_q == stex_pkg::STEP_ST) ? cmd_q.st : stex_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= stex_pkg::STEP_PFX0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_valid && pop_ready) begin
				busy_q <= 1'b1;
				step_q <= step_start;
			end else if (advance) begin
				if (last_step) busy_q <= 1'b0;
				step_q <= step_next;
			end
			if (advance) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign is_status = is_status_q;
	assign out_char = char_q;
	assign status = status_q;
	assign last_result = last_result_q;

endmodule

[dv/tb_simple_tlv_serial_extractor_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for simple_tlv_serial_extractor_top: file streams of
// simple-TLV records, a byte-level predictor in a scoreboard class, random flow control.
// Depends on stex_pkg and the extractor RTL.

import stex_pkg::*;

typedef struct packed {
	logic       is_st;
	logic [7:0] ch;
	logic [1:0] st;
	logic       lst;
} tlv_beat_t;

class serial_tracker;
	phase_t      ph;
	logic [15:0] remain;
	logic        matched;
	logic [7:0]  len_hi;
	logic        thirteen;
	logic        first;
	logic [7:0]  tag;
	tlv_beat_t   owed_beats[$];
	int          errors;
	string       digits;

	function new();
		ph       = PH_TAG;
		remain   = '0;
		matched  = 1'b0;
		len_hi   = '0;
		thirteen = 1'b0;
		first    = 1'b1;
		tag      = TAG_RESET;
		errors   = 0;
		digits   = "0123456789ABCDEF";
	endfunction

	function void set_target(logic [7:0] v);
		tag = v;
	endfunction

	function int pending();
		return owed_beats.size();
	endfunction

	function void owe_char(logic [7:0] c);
		owed_beats.push_back('{1'b0, c, ST_OK, 1'b0});
	endfunction

	function void close_run(logic [1:0] st, logic lst);
		owed_beats.push_back('{1'b1, 8'h00, st, 1'b1});
		ph = lst ? PH_TAG : PH_DONE;
	endfunction

	function void header_done(logic lst);
		if (matched) begin
			if (remain == 16'd0) close_run(ST_EMPTY, lst);
			else if (lst) close_run(ST_OVERRUN, lst);
			else begin
				thirteen = (remain == LEN_THIRTEEN);
				first    = 1'b1;
				ph       = PH_VALUE;
			end
		end else if (lst) begin
			close_run(ST_NOTFOUND, lst);
		end else begin
			ph = (remain == 16'd0) ? PH_TAG : PH_SKIP;
		end
	endfunction

	// Predict the beats caused by one accepted file byte
	function void take_byte(logic [7:0] b, logic lst);
		case (ph)
			PH_LEN: begin
				if (b == LEN_EXT) begin
					if (lst) close_run(ST_NOTFOUND, lst);
					else ph = PH_LENHI;
				end else begin
					remain = {8'h00, b};
					header_done(lst);
				end
			end
			PH_LENHI: begin
				len_hi = b;
				if (lst) close_run(ST_NOTFOUND, lst);
				else ph = PH_LENLO;
			end
			PH_LENLO: begin
				remain = {len_hi, b};
				header_done(lst);
			end
			PH_SKIP: begin
				remain = remain - 16'd1;
				if (lst) close_run(ST_NOTFOUND, lst);
				else if (remain == 16'd0) ph = PH_TAG;
			end
			PH_VALUE: begin
				// leading FF value byte gets the FF0000 marker ahead of it
				if (first && b == 8'hFF) begin
					owe_char(CHAR_F);
					owe_char(CHAR_F);
					repeat (4) owe_char(CHAR_0);
				end
				first = 1'b0;
				owe_char(digits[b[7:4]]);
				owe_char(digits[b[3:0]]);
				remain = remain - 16'd1;
				if (remain == 16'd0) close_run(ST_OK, lst);
				else if (lst) close_run((thirteen && remain == 16'd1) ? ST_OK : ST_OVERRUN, lst);
			end
			PH_DONE: begin
				if (lst) ph = PH_TAG;
			end
			default: begin
				matched = (b == tag);
				if (lst) close_run(ST_NOTFOUND, lst);
				else ph = PH_LEN;
			end
		endcase
	endfunction

	task flag(string msg);
		errors++;
		if (errors <= 40) $display("MISMATCH: %s", msg);
	endtask

	task match_beat(logic is_st, logic [7:0] ch, logic [1:0] st, logic lst);
		tlv_beat_t e;
		if (owed_beats.size() == 0) begin
			flag($sformatf("beat with none owed: is_status=%0b char=%02h status=%0d last=%0b",
				is_st, ch, st, lst));
			return;
		end
		e = owed_beats.pop_front();
		if (is_st !== e.is_st) flag($sformatf("is_status %0b, want %0b", is_st, e.is_st));
		if (ch !== e.ch) flag($sformatf("out_char %02h, want %02h", ch, e.ch));
		if (st !== e.st) flag($sformatf("status %0d, want %0d", st, e.st));
		if (lst !== e.lst) flag($sformatf("last_result %0b, want %0b", lst, e.lst));
	endtask
endclass

module tb_simple_tlv_serial_extractor_top;
	localparam int SETTLE      = 8;
	localparam int LONG_HOLD   = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_BYTES = 16;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       is_status;
	logic [7:0] out_char;
	logic [1:0] status;
	logic       last_result;

	serial_tracker tracker;
	logic [7:0]    file_bytes[$];
	int            burst_left = 0;
	int            bytes_sent = 0;
	int            hold_reqs = 0;
	int            holds_done = 0;

	// bit 8 marks the last byte of a file
	logic [8:0] dir_seq [22] = '{
		9'h15A,
		9'h05A, 9'h1FF,
		9'h05A, 9'h0FF, 9'h100,
		9'h05A, 9'h000, 9'h177,
		9'h05A, 9'h001, 9'h0FF, 9'h13C,
		9'h011, 9'h001, 9'h122,
		9'h011, 9'h000, 9'h05A, 9'h003, 9'h000, 9'h19F
	};

	simple_tlv_serial_extractor_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.is_status  (is_status),
		.out_char   (out_char),
		.status     (status),
		.last_result(last_result)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) tracker.take_byte(in_byte, last_byte);
			if (out_valid && out_ready) tracker.match_beat(is_status, out_char, status, last_result);
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
			else idle++;
		end
		$display("Mismatches found");
		$finish;
	end

	// Receiver: stall pattern drawn at random (always ready, periodic stalls, coin flip); long hold-off on request
	initial begin
		int unsigned cnt;
		int unsigned mode;
		cnt  = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (hold_reqs != holds_done) begin
				holds_done++;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			if (cnt % 48 == 0) mode = $urandom_range(0, 2);
			cnt++;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= (cnt % 4 != 0);
				default: out_ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	// Called at a falling edge, returns at the falling edge after the beat is taken
	task automatic send_byte(input logic [7:0] b, input logic lst);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 12);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		in_byte   <= b;
		last_byte <= lst;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic retarget(input logic [7:0] v);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.set_target(v);
	endtask

	// kind 0..4 picks the length form of the matching record, anything above is noise
	task automatic make_file(input int unsigned kind, input logic [7:0] want);
		int unsigned n;
		int unsigned vlen;
		int unsigned nbody;
		int unsigned nskip;
		int unsigned ending;
		int          i;
		logic [7:0]  t;
		logic [7:0]  hi;
		logic [7:0]  lo;
		logic        huge;
		file_bytes.delete();
		if (kind > 4) begin
			n = $urandom_range(1, 6);
			repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		nskip = $urandom_range(0, 2);
		huge  = 1'b0;
		for (i = 0; i < nskip && !huge; i++) begin
			do t = 8'($urandom_range(0, 255)); while (t == want);
			file_bytes.push_back(t);
			case ($urandom_range(0, 5))
				0, 1, 2: begin
					n = $urandom_range(0, 4);
					file_bytes.push_back(n[7:0]);
				end
				3, 4: begin
					n = $urandom_range(0, 3);
					file_bytes.push_back(LEN_EXT);
					file_bytes.push_back(8'h00);
					file_bytes.push_back(n[7:0]);
				end
				default: begin
					// long skipped record, the file ends inside it
					file_bytes.push_back(LEN_EXT);
					file_bytes.push_back(8'($urandom_range(1, 255)));
					file_bytes.push_back(8'($urandom_range(0, 255)));
					n    = $urandom_range(0, 3);
					huge = 1'b1;
				end
			endcase
			repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
		end
		if (huge) return;
		file_bytes.push_back(want);
		case (kind)
			0: vlen = 0;
			1: vlen = $urandom_range(1, 6);
			2: vlen = 13;
			3: vlen = $urandom_range(0, 6);
			default: vlen = $urandom_range(256, 65535);
		endcase
		if (kind >= 3) begin
			hi = vlen[15:8];
			lo = vlen[7:0];
			file_bytes.push_back(LEN_EXT);
			file_bytes.push_back(hi);
			file_bytes.push_back(lo);
		end else begin
			file_bytes.push_back(vlen[7:0]);
		end
		nbody = (vlen > 16) ? 16 : vlen;
		for (i = 0; i < nbody; i++) begin
			t = 8'($urandom_range(0, 255));
			if (i == 0 && $urandom_range(0, 2) == 0) t = 8'hFF;
			file_bytes.push_back(t);
		end
		if (vlen > 16) return;
		ending = $urandom_range(0, 3);
		if (kind == 2 && ending < 2) begin
			void'(file_bytes.pop_back());
		end else if (ending == 0 && file_bytes.size() > 1) begin
			n = $urandom_range(1, file_bytes.size() - 1);
			while (file_bytes.size() > n) void'(file_bytes.pop_back());
		end else if (ending == 1) begin
			repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic send_file();
		int i;
		for (i = 0; i < file_bytes.size(); i++)
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
	endtask

	initial begin
		int          i;
		int          p;
		int          start;
		int unsigned kind;
		logic [7:0]  tag;
		tracker = new();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset target tag still in force
		for (i = 0; i < 22; i++) send_byte(dir_seq[i][7:0], dir_seq[i][8]);
		wait_results_done();

		for (p = 0; p < 5; p++) begin
			case (p)
				0: tag = 8'h00;
				1: tag = 8'hFF;
				4: tag = TAG_RESET;
				default: tag = 8'($urandom_range(0, 255));
			endcase
			retarget(tag);
			if (p == 3) hold_reqs++;
			start = bytes_sent;
			kind  = p;
			while (bytes_sent - start < PHASE_BYTES) begin
				make_file(kind, tag);
				send_file();
				kind = $urandom_range(0, 5);
			end
			wait_results_done();
		end

		repeat (20) @(negedge clk);
		if (tracker.pending() != 0)
			tracker.flag($sformatf("%0d beats never arrived", tracker.pending()));
		if (tracker.errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule
